// ----- hw/rtl/grtt_pkg.sv -----
// shared types and constants for the guest range translation table
package grtt_pkg;

  localparam int unsigned MaxRanges = 64;
  localparam int unsigned AddrBits  = 48;
  localparam int unsigned IdxBits   = $clog2(MaxRanges);
  localparam int unsigned CntBits   = $clog2(MaxRanges + 1);

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [CntBits-1:0]  cnt_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERLAP  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  localparam logic [2:0] KindPhys    = 3'd0;
  localparam logic [2:0] KindInvalid = 3'd6;

  typedef struct packed {
    logic [1:0] opcode;
    addr_t      range_start;
    addr_t      range_end;
    logic [2:0] region_kind;
    addr_t      host_base;
    addr_t      query_address;
    logic [5:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] found_kind;
    addr_t      host_address;
    addr_t      entry_start;
    addr_t      entry_end;
    logic [6:0] region_count;
  } rsp_t;

  // classified command from front to back
  typedef struct packed {
    op_e        op;
    logic       idx_ok;
    idx_t       idx;
    addr_t      a_start;
    addr_t      a_end;
    logic [2:0] kind;
    addr_t      host;
    addr_t      query;
  } cmd_t;

  typedef struct packed {
    addr_t      s;
    addr_t      e;
    addr_t      h;
    logic [2:0] k;
  } entry_t;

endpackage

// ----- hw/rtl/grtt_front.sv -----
// front part: accepts items and classifies them into commands
module grtt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid,
  output logic          in_ready,
  input  grtt_pkg::req_t in_data,
  input  grtt_pkg::cnt_t count_i,
  input  logic          done_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output grtt_pkg::cmd_t cmd_o
);
  import grtt_pkg::*;

  logic busy_q, busy_d;

  // one item in flight; count is stable once the back part has finished
  always_comb begin
    busy_d = busy_q;
    if (done_i) busy_d = 1'b0;
    if (in_valid && in_ready) busy_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else busy_q <= busy_d;
  end

  assign in_ready    = !busy_q && cmd_ready_i;
  assign cmd_valid_o = in_valid && in_ready;

  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = op_e'(in_data.opcode);
    cmd_o.idx     = in_data.entry_index[IdxBits-1:0];
    cmd_o.idx_ok  = CntBits'(in_data.entry_index) < count_i;
    cmd_o.a_start = in_data.range_start;
    cmd_o.a_end   = in_data.range_end;
    cmd_o.kind    = in_data.region_kind;
    cmd_o.host    = in_data.host_base;
    cmd_o.query   = in_data.query_address;
  end
endmodule

// ----- hw/rtl/grtt_queue.sv -----
// two-entry command queue between front and back
module grtt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  grtt_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output grtt_pkg::cmd_t rd_data_o
);
  import grtt_pkg::*;

  cmd_t     mem_q [2];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_valid_i && wr_ready_o) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_valid_i && wr_ready_o) wp_q <= ~wp_q;
      if (rd_valid_o && rd_ready_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_valid_i && wr_ready_o) - 2'(rd_valid_o && rd_ready_i);
    end
  end
endmodule

// ----- hw/rtl/grtt_back.sv -----
// back part: table memory and sequencer for insert, lookup and read
module grtt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  grtt_pkg::cmd_t cmd_i,
  output grtt_pkg::cnt_t count_o,
  output logic           out_valid,
  input  logic           out_ready,
  output grtt_pkg::rsp_t out_data
);
  import grtt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_RDWT  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  cnt_t   count_q, count_d;
  cnt_t   ptr_q, ptr_d;
  cnt_t   pos_q, pos_d;
  logic   pos_found_q, pos_found_d;
  rsp_t   rsp_q, rsp_d;

  entry_t mem [MaxRanges];
  entry_t rdat_q;
  idx_t   raddr;
  logic   we;
  idx_t   waddr;
  entry_t wdat;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdat;
    rdat_q <= mem[raddr];
  end

  assign count_o     = count_q;
  assign cmd_ready_o = state_q == S_IDLE;
  assign out_valid   = state_q == S_RESP;
  assign out_data    = rsp_q;

  addr_t diff;
  assign diff = cmd_q.query - rdat_q.s;

  function automatic rsp_t miss(input logic [1:0] st, input cnt_t c);
    rsp_t r;
    r = '0;
    r.status = st;
    r.found_kind = KindInvalid;
    r.region_count = 7'(c);
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    count_d = count_q;
    ptr_d = ptr_q;
    pos_d = pos_q;
    pos_found_d = pos_found_q;
    rsp_d = rsp_q;
    raddr = ptr_q[IdxBits-1:0];
    we = 1'b0;
    waddr = ptr_q[IdxBits-1:0];
    wdat = rdat_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          ptr_d = '0;
          pos_d = count_q;
          pos_found_d = 1'b0;
          case (cmd_i.op)
            OP_INSERT: begin
              if (count_q >= CntBits'(MaxRanges)) begin
                rsp_d = miss(ST_FULL, count_q);
                state_d = S_RESP;
              end else if (count_q == '0) begin
                state_d = S_SHWR;
                ptr_d = '0;
              end else state_d = S_SCAN;
            end
            OP_LOOKUP: begin
              if (count_q == '0) begin
                rsp_d = miss(ST_NOTFOUND, count_q);
                state_d = S_RESP;
              end else state_d = S_SCAN;
            end
            OP_READ: begin
              if (cmd_i.idx_ok) begin
                ptr_d = CntBits'(cmd_i.idx);
                raddr = cmd_i.idx;
                state_d = S_RDWT;
              end else begin
                rsp_d = miss(ST_NOTFOUND, count_q);
                state_d = S_RESP;
              end
            end
            default: begin
              rsp_d = miss(ST_NOTFOUND, count_q);
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: state_d = S_CHK;
      S_CHK: begin
        if (cmd_q.op == OP_INSERT) begin
          if (rdat_q.s < cmd_q.a_end && cmd_q.a_start < rdat_q.e) begin
            rsp_d = miss(ST_OVERLAP, count_q);
            state_d = S_RESP;
          end else begin
            if (!pos_found_q && rdat_q.s > cmd_q.a_start) begin
              pos_found_d = 1'b1;
              pos_d = ptr_q;
            end
            if (ptr_q + 1'b1 == count_q) begin
              ptr_d = count_q;
              state_d = (pos_d == count_q) ? S_SHWR : S_SHRD;
            end else begin
              ptr_d = ptr_q + 1'b1;
              state_d = S_SCAN;
            end
          end
        end else begin
          if (rdat_q.s <= cmd_q.query && cmd_q.query < rdat_q.e) begin
            rsp_d = '0;
            rsp_d.status = ST_OK;
            rsp_d.found_kind = rdat_q.k;
            rsp_d.host_address = (rdat_q.k == KindPhys) ? diff + rdat_q.h : '0;
            rsp_d.entry_start = rdat_q.s;
            rsp_d.entry_end = rdat_q.e;
            rsp_d.region_count = 7'(count_q);
            state_d = S_RESP;
          end else if (ptr_q + 1'b1 == count_q) begin
            rsp_d = miss(ST_NOTFOUND, count_q);
            state_d = S_RESP;
          end else begin
            ptr_d = ptr_q + 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SHRD: begin
        // read entry ptr-1 for moving up one slot
        raddr = IdxBits'(ptr_q - 1'b1);
        state_d = S_SHWR;
      end
      S_SHWR: begin
        we = 1'b1;
        waddr = ptr_q[IdxBits-1:0];
        if (ptr_q == pos_q) begin
          wdat.s = cmd_q.a_start;
          wdat.e = cmd_q.a_end;
          wdat.h = cmd_q.host;
          wdat.k = cmd_q.kind;
          count_d = count_q + 1'b1;
          rsp_d = miss(ST_OK, count_q + 1'b1);
          state_d = S_RESP;
        end else begin
          wdat = rdat_q;
          ptr_d = ptr_q - 1'b1;
          state_d = (ptr_q - 1'b1 == pos_q) ? S_SHWR : S_SHRD;
        end
      end
      S_RDWT: begin
        state_d = S_RESP;
        rsp_d = '0;
        rsp_d.status = ST_OK;
        rsp_d.found_kind = rdat_q.k;
        rsp_d.host_address = rdat_q.h;
        rsp_d.entry_start = rdat_q.s;
        rsp_d.entry_end = rdat_q.e;
        rsp_d.region_count = 7'(count_q);
      end
      S_RESP: if (out_ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q <= '0;
      pos_q <= '0;
      pos_found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q <= ptr_d;
      pos_q <= pos_d;
      pos_found_q <= pos_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rsp_q <= rsp_d;
  end
endmodule

// ----- hw/rtl/guest_range_translation_table_top.sv -----
// Per item: a read does one table read; a lookup scans the entries in order until a hit or the
// last entry; an insert scans for overlap and position, shifts any later entries up one slot and
// writes the new entry (an overlap ends the scan early); a full table, an empty-table lookup, a
// bad index or the unused opcode answer without a table access. One item at a time: the next is
// accepted from the cycle after the result is taken. Reset clears count and control only.
// top level of the guest range translation table
module guest_range_translation_table_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_ready,
  input  grtt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output grtt_pkg::rsp_t out_data
);
  import grtt_pkg::*;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t fq_cmd, qb_cmd;
  cnt_t count;

  grtt_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data,
    .count_i(count), .done_i(out_valid && out_ready),
    .cmd_valid_o(fq_valid), .cmd_ready_i(fq_ready), .cmd_o(fq_cmd)
  );

  grtt_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_cmd),
    .rd_valid_o(qb_valid), .rd_ready_i(qb_ready), .rd_data_o(qb_cmd)
  );

  grtt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(qb_valid), .cmd_ready_o(qb_ready), .cmd_i(qb_cmd),
    .count_o(count), .out_valid, .out_ready, .out_data
  );

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntBits'(MaxRanges)) else $error("count overflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count != $past(count) |-> count == $past(count) + 1'b1) else $error("bad count step");
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.region_count == 7'(count)) else $error("count mismatch");
endmodule
